// ===== rtl/kts_pkg.sv =====
// Package for the keyword token trie: sizes, codes and the structs that
// travel between the top level, the cell chain and the node cells.
// Depends on nothing.
`default_nettype none

package kts_pkg;

  localparam int MAX_NODES = 256;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = NODE_W + 1;
  localparam int TOKEN_W   = 10;
  localparam int PHRASE_W  = 8;
  localparam int BOOST_W   = 16;
  localparam int THR_W     = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  localparam logic [1:0] MK_ROOT       = 2'd0;
  localparam logic [1:0] MK_CHILD      = 2'd1;
  localparam logic [1:0] MK_ROOT_CHILD = 2'd2;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [7:0]                node;
    logic [TOKEN_W-1:0]        token;
    logic                      last_token;
    logic signed [BOOST_W-1:0] boost;
    logic [THR_W-1:0]          threshold;
    logic [PHRASE_W-1:0]       phrase_id;
  } kts_req_t;

  typedef struct packed {
    logic [7:0]                next_node;
    logic signed [BOOST_W-1:0] reached_boost;
    logic [1:0]                match_kind;
    logic                      at_end;
    logic [THR_W-1:0]          end_threshold;
    logic [PHRASE_W-1:0]       end_phrase;
    logic                      table_full;
  } kts_rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0]         idx;
    logic signed [BOOST_W-1:0] boost;
    logic                      is_end;
    logic [THR_W-1:0]          thr;
    logic [PHRASE_W-1:0]       phr;
  } slot_t;

  typedef struct packed {
    logic  vld;
    logic  f1;
    slot_t s1;
    logic  f2;
    slot_t s2;
  } acc_t;

  typedef struct packed {
    logic               insert;
    logic [NODE_W-1:0]  par;
    logic [TOKEN_W-1:0] tok;
  } key_t;

  typedef struct packed {
    logic                      en;
    logic [NODE_W-1:0]         idx;
    logic                      create;
    logic [NODE_W-1:0]         par;
    logic [TOKEN_W-1:0]        tok;
    logic signed [BOOST_W-1:0] boost;
    logic                      last;
    logic [THR_W-1:0]          thr;
    logic [PHRASE_W-1:0]       phr;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/kts_in_if.sv =====
// Request channel of the keyword token trie: valid, ready and one request.
// Depends on kts_pkg.
`default_nettype none

interface kts_in_if;
  logic              valid;
  logic              ready;
  kts_pkg::kts_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kts_out_if.sv =====
// Result channel of the keyword token trie: valid, ready and one result.
// Depends on kts_pkg.
`default_nettype none

interface kts_out_if;
  logic              valid;
  logic              ready;
  kts_pkg::kts_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/kts_cell.sv =====
// One trie node cell: holds the node's fields and merges its matches into the
// search record that passes through it toward the next cell.
// Depends on kts_pkg.
`default_nettype none

module kts_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire logic [kts_pkg::NODE_W-1:0]  index_i,
  input  wire logic [kts_pkg::COUNT_W-1:0] count_i,
  input  wire kts_pkg::key_t               key_i,
  input  wire kts_pkg::wr_t                wr_i,
  input  wire kts_pkg::acc_t               acc_i,
  output      kts_pkg::acc_t               acc_o
);

  logic [kts_pkg::NODE_W-1:0]         par_q;
  logic [kts_pkg::TOKEN_W-1:0]        tok_q;
  logic signed [kts_pkg::BOOST_W-1:0] boost_q;
  logic                               end_q;
  logic [kts_pkg::THR_W-1:0]          thr_q;
  logic [kts_pkg::PHRASE_W-1:0]       phr_q;
  kts_pkg::acc_t                      acc_d, acc_q;
  kts_pkg::slot_t                     mine;
  logic                               live, m1, m2;

  assign live = (index_i != '0) && ({1'b0, index_i} < count_i);
  assign m1   = live && (par_q == key_i.par) && (tok_q == key_i.tok);
  assign m2   = key_i.insert ? (index_i == key_i.par)
                             : (live && (par_q == '0) && (tok_q == key_i.tok));

  always_comb begin
    mine.idx    = index_i;
    mine.boost  = boost_q;
    mine.is_end = end_q;
    mine.thr    = thr_q;
    mine.phr    = phr_q;
    acc_d = acc_i;
    if (acc_i.vld) begin
      if (m1 && !acc_i.f1) begin
        acc_d.f1 = 1'b1;
        acc_d.s1 = mine;
      end
      if (m2 && !acc_i.f2) begin
        acc_d.f2 = 1'b1;
        acc_d.s2 = mine;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      end_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (wr_i.en && (wr_i.idx == index_i)) begin
        end_q <= wr_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == index_i)) begin
      boost_q <= wr_i.boost;
      if (wr_i.create) begin
        par_q <= wr_i.par;
        tok_q <= wr_i.tok;
      end
      if (wr_i.last) begin
        thr_q <= wr_i.thr;
        phr_q <= wr_i.phr;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/kts_chain.sv =====
// Row of node cells; the search record enters at cell zero and moves one cell
// per cycle. Depends on kts_pkg and kts_cell.
`default_nettype none

module kts_chain (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire logic [kts_pkg::COUNT_W-1:0] count_i,
  input  wire kts_pkg::key_t               key_i,
  input  wire kts_pkg::wr_t                wr_i,
  input  wire kts_pkg::acc_t               head_i,
  output      kts_pkg::acc_t               tail_o
);

  kts_pkg::acc_t link [kts_pkg::MAX_NODES+1];

  assign link[0] = head_i;

  for (genvar i = 0; i < kts_pkg::MAX_NODES; i++) begin : g_cell
    kts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .index_i (kts_pkg::NODE_W'(i)),
      .count_i (count_i),
      .key_i   (key_i),
      .wr_i    (wr_i),
      .acc_i   (link[i]),
      .acc_o   (link[i+1])
    );
  end

  assign tail_o = link[kts_pkg::MAX_NODES];

endmodule

`default_nettype wire

// ===== rtl/keyword_trie_step.sv =====
// Keyword token trie: request sequencing, node count, insert cursor and result
// register. Depends on kts_pkg, kts_in_if, kts_out_if and kts_chain.
//
// Requests arrive on req_i and results leave on rsp_o; both use valid/ready and
// every request gives exactly one result. Clear empties the trie to the root,
// insert adds one keyword token at the insert cursor, step follows a token from
// a node with fallback to the root's child.
// The block takes one request at a time. Insert and step send a search record
// down a row of MAX_NODES node cells, one cell per cycle; the record that
// leaves the last cell is registered, and the final state then loads the
// result into the output register. Clear and the unused opcode skip the search
// and go straight to the final state. The next request is taken in the cycle
// after the result is loaded into the output register, even while that result
// still waits for the receiver. When the receiver stalls, a finished result
// waits in the final state until the output register frees up, and no new
// request is taken. Reset leaves only the root node, puts the insert cursor on
// the root and empties the output register; no clearing pass is needed.
`default_nettype none

module keyword_trie_step (
  input  wire      clk_i,
  input  wire      rst_ni,
  kts_in_if.sink   req_i,
  kts_out_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FIN    = 3'b100
  } state_e;

  state_e                         state_q, state_d;
  kts_pkg::kts_req_t              req_q;
  logic [kts_pkg::NODE_W-1:0]     node_q;
  logic                           launch_q;
  kts_pkg::acc_t                  tail_q, tail_w, head_w;
  logic [kts_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [kts_pkg::NODE_W-1:0]     cursor_q, cursor_d;
  logic                           out_valid_q;
  kts_pkg::kts_rsp_t              out_q, rsp;
  kts_pkg::key_t                  key;
  kts_pkg::wr_t                   wr, wr_w;
  kts_pkg::slot_t                 sel;
  logic                           hit, full, accept, commit, is_end;
  logic [1:0]                     kind;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign commit      = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  assign key.insert = (req_q.opcode == kts_pkg::OP_INSERT);
  assign key.par    = key.insert ? cursor_q : node_q;
  assign key.tok    = req_q.token;

  always_comb begin
    head_w     = '0;
    head_w.vld = launch_q;
  end

  assign wr_w = commit ? wr : '0;

  kts_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (count_q),
    .key_i   (key),
    .wr_i    (wr_w),
    .head_i  (head_w),
    .tail_o  (tail_w)
  );

  always_comb begin
    sel      = '0;
    hit      = 1'b0;
    full     = 1'b0;
    kind     = kts_pkg::MK_ROOT;
    wr       = '0;
    count_d  = count_q;
    cursor_d = cursor_q;
    unique case (req_q.opcode)
      kts_pkg::OP_CLEAR: begin
        count_d  = kts_pkg::COUNT_W'(1);
        cursor_d = '0;
      end
      kts_pkg::OP_INSERT: begin
        if (tail_q.f1) begin
          sel  = tail_q.s1;
          hit  = 1'b1;
          kind = kts_pkg::MK_CHILD;
          if (req_q.last_token) begin
            sel.boost  = req_q.boost;
            sel.is_end = 1'b1;
            sel.thr    = req_q.threshold;
            sel.phr    = req_q.phrase_id;
            wr.en      = 1'b1;
            wr.idx     = tail_q.s1.idx;
            wr.boost   = req_q.boost;
            wr.last    = 1'b1;
            wr.thr     = req_q.threshold;
            wr.phr     = req_q.phrase_id;
          end
          cursor_d = req_q.last_token ? '0 : tail_q.s1.idx;
        end else if (count_q >= kts_pkg::COUNT_W'(kts_pkg::MAX_NODES)) begin
          sel      = tail_q.s2;
          hit      = (cursor_q != '0);
          full     = 1'b1;
          cursor_d = req_q.last_token ? '0 : cursor_q;
        end else begin
          sel.idx    = count_q[kts_pkg::NODE_W-1:0];
          sel.boost  = req_q.boost;
          sel.is_end = req_q.last_token;
          sel.thr    = req_q.threshold;
          sel.phr    = req_q.phrase_id;
          hit        = 1'b1;
          wr.en      = 1'b1;
          wr.idx     = count_q[kts_pkg::NODE_W-1:0];
          wr.create  = 1'b1;
          wr.par     = cursor_q;
          wr.tok     = req_q.token;
          wr.boost   = req_q.boost;
          wr.last    = req_q.last_token;
          wr.thr     = req_q.threshold;
          wr.phr     = req_q.phrase_id;
          count_d    = count_q + kts_pkg::COUNT_W'(1);
          cursor_d   = req_q.last_token ? '0 : count_q[kts_pkg::NODE_W-1:0];
        end
      end
      kts_pkg::OP_STEP: begin
        if (tail_q.f1) begin
          sel  = tail_q.s1;
          hit  = 1'b1;
          kind = kts_pkg::MK_CHILD;
        end else if ((node_q != '0) && tail_q.f2) begin
          sel  = tail_q.s2;
          hit  = 1'b1;
          kind = kts_pkg::MK_ROOT_CHILD;
        end
      end
      default: begin
      end
    endcase
    is_end            = hit && sel.is_end;
    rsp.next_node     = hit ? 8'(sel.idx) : '0;
    rsp.reached_boost = hit ? sel.boost : '0;
    rsp.match_kind    = kind;
    rsp.at_end        = is_end;
    rsp.end_threshold = is_end ? sel.thr : '0;
    rsp.end_phrase    = is_end ? sel.phr : '0;
    rsp.table_full    = full;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((req_i.data.opcode == kts_pkg::OP_INSERT) ||
              (req_i.data.opcode == kts_pkg::OP_STEP)) begin
            state_d = S_SEARCH;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SEARCH: begin
        if (tail_w.vld) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      count_q     <= kts_pkg::COUNT_W'(1);
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept && (state_d == S_SEARCH);
      if (commit) begin
        count_q     <= count_d;
        cursor_q    <= cursor_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i.data;
      node_q <= ({1'b0, req_i.data.node} >= count_q) ? '0
                                                     : req_i.data.node[kts_pkg::NODE_W-1:0];
    end
    if ((state_q == S_SEARCH) && tail_w.vld) begin
      tail_q <= tail_w;
    end
    if (commit) begin
      out_q <= rsp;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

// ===== sim/tb_keyword_trie_step.sv =====
// Testbench for the keyword token trie: a directed opening, then random keyword
// inserts, trie walks, clears and noise under four idling patterns, each result checked
// against a mirror. Depends on kts_pkg, kts_in_if, kts_out_if and keyword_trie_step.
`default_nettype none

module tb_keyword_trie_step;
  timeunit 1ns;
  timeprecision 1ps;

  import kts_pkg::*;

  localparam logic [1:0]         OP_UNUSED   = 2'd3;
  localparam logic [TOKEN_W-1:0] TOKEN_TOP   = '1;
  localparam int unsigned        QUIET_LIMIT = 4000;
  localparam int unsigned        KW_SLOTS    = 64;

  class trie_mirror;
    logic [NODE_W-1:0]         parent_of [MAX_NODES];
    logic [TOKEN_W-1:0]        token_of  [MAX_NODES];
    logic signed [BOOST_W-1:0] boost_of  [MAX_NODES];
    bit                        ends_here [MAX_NODES];
    logic [THR_W-1:0]          thr_of    [MAX_NODES];
    logic [PHRASE_W-1:0]       phrase_of [MAX_NODES];
    int unsigned               node_count;
    int unsigned               cursor;
    kts_rsp_t                  awaited_rsp [$];
    int unsigned               mismatches;

    function new();
      node_count = 1;
      cursor = 0;
      mismatches = 0;
      foreach (ends_here[i]) ends_here[i] = 1'b0;
    endfunction

    function int unsigned child_of(int unsigned par, logic [TOKEN_W-1:0] tok);
      for (int unsigned i = 1; i < node_count; i++) begin
        if (parent_of[i] == par && token_of[i] == tok) return i;
      end
      return 0;
    endfunction

    function kts_rsp_t node_view(int unsigned n, logic [1:0] kind, bit full);
      kts_rsp_t r;
      r = '0;
      r.next_node = 8'(n);
      r.match_kind = kind;
      r.table_full = full;
      if (n != 0) begin
        r.reached_boost = boost_of[n];
        if (ends_here[n]) begin
          r.at_end = 1'b1;
          r.end_threshold = thr_of[n];
          r.end_phrase = phrase_of[n];
        end
      end
      return r;
    endfunction

    function kts_rsp_t trie_answer(kts_req_t q);
      int unsigned cur;
      int unsigned n;
      int unsigned from;
      logic [1:0]  kind;
      case (q.opcode)
        OP_CLEAR: begin
          node_count = 1;
          cursor = 0;
          ends_here[0] = 1'b0;
          return node_view(0, MK_ROOT, 1'b0);
        end
        OP_INSERT: begin
          cur = cursor;
          kind = MK_CHILD;
          n = child_of(cur, q.token);
          if (n == 0) begin
            if (node_count >= MAX_NODES) begin
              if (q.last_token) cursor = 0;
              return node_view(cur, MK_ROOT, 1'b1);
            end
            n = node_count;
            parent_of[n] = NODE_W'(cur);
            token_of[n] = q.token;
            boost_of[n] = q.boost;
            ends_here[n] = 1'b0;
            node_count++;
            kind = MK_ROOT;
          end
          if (q.last_token) begin
            ends_here[n] = 1'b1;
            boost_of[n] = q.boost;
            thr_of[n] = q.threshold;
            phrase_of[n] = q.phrase_id;
            cursor = 0;
          end else begin
            cursor = n;
          end
          return node_view(n, kind, 1'b0);
        end
        OP_STEP: begin
          from = (q.node >= node_count) ? 0 : q.node;
          n = child_of(from, q.token);
          if (n != 0) return node_view(n, MK_CHILD, 1'b0);
          if (from != 0) begin
            n = child_of(0, q.token);
            if (n != 0) return node_view(n, MK_ROOT_CHILD, 1'b0);
          end
          return node_view(0, MK_ROOT, 1'b0);
        end
        default: return node_view(0, MK_ROOT, 1'b0);
      endcase
    endfunction

    function kts_rsp_t take_request(kts_req_t q);
      kts_rsp_t e;
      e = trie_answer(q);
      awaited_rsp = {awaited_rsp, e};
      return e;
    endfunction

    function void compare_field(string name, logic [15:0] e, logic [15:0] a);
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 40) $display("%0t: %s expected %h got %h", $time, name, e, a);
      end
    endfunction

    function void check_result(kts_rsp_t got);
      kts_rsp_t e;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 40) $display("%0t: unexpected result expected none got %h", $time, got);
        return;
      end
      e = awaited_rsp.pop_front();
      compare_field("next_node", 16'(e.next_node), 16'(got.next_node));
      compare_field("reached_boost", e.reached_boost, got.reached_boost);
      compare_field("match_kind", 16'(e.match_kind), 16'(got.match_kind));
      compare_field("at_end", 16'(e.at_end), 16'(got.at_end));
      compare_field("end_threshold", e.end_threshold, got.end_threshold);
      compare_field("end_phrase", 16'(e.end_phrase), 16'(got.end_phrase));
      compare_field("table_full", 16'(e.table_full), 16'(got.table_full));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kts_in_if  req_if ();
  kts_out_if rsp_if ();

  keyword_trie_step uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  trie_mirror         mirror = new();
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        items_sent = 0;
  int unsigned        quiet_cycles = 0;
  kts_rsp_t           last_answer;
  logic [TOKEN_W-1:0] kw_tok [KW_SLOTS][4];
  int unsigned        kw_len [KW_SLOTS];
  int unsigned        kw_total = 0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      mirror.check_result(rsp_if.data);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic kts_req_t req_of(logic [1:0] op, logic [7:0] node,
                                      logic [TOKEN_W-1:0] tok, logic last,
                                      logic [BOOST_W-1:0] boost, logic [THR_W-1:0] thr,
                                      logic [PHRASE_W-1:0] phr);
    kts_req_t q;
    q.opcode = op;
    q.node = node;
    q.token = tok;
    q.last_token = last;
    q.boost = boost;
    q.threshold = thr;
    q.phrase_id = phr;
    return q;
  endfunction

  function automatic int unsigned known_slot();
    return $urandom_range(0, ((kw_total < KW_SLOTS) ? kw_total : KW_SLOTS) - 1);
  endfunction

  task automatic send(input kts_req_t q);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= q;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    last_answer = mirror.take_request(q);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic insert_keyword(int unsigned len, bit wide);
    int unsigned        slot;
    logic [TOKEN_W-1:0] t;
    slot = kw_total % KW_SLOTS;
    kw_len[slot] = len;
    kw_total++;
    for (int unsigned i = 0; i < len; i++) begin
      if (wide || $urandom_range(0, 9) < 3) t = TOKEN_W'($urandom);
      else if ($urandom_range(0, 9) == 0) t = TOKEN_TOP - TOKEN_W'($urandom_range(0, 3));
      else t = TOKEN_W'($urandom_range(0, 7));
      kw_tok[slot][i] = t;
      send(req_of(OP_INSERT, 8'($urandom), t, i == len - 1, BOOST_W'($urandom),
                  THR_W'($urandom), PHRASE_W'($urandom)));
    end
  endtask

  task automatic walk_keyword(int unsigned slot);
    logic [7:0]         at;
    logic [TOKEN_W-1:0] t;
    at = '0;
    for (int unsigned i = 0; i < kw_len[slot]; i++) begin
      t = ($urandom_range(0, 9) == 0) ? TOKEN_W'($urandom) : kw_tok[slot][i];
      send(req_of(OP_STEP, at, t, 1'($urandom), BOOST_W'($urandom), THR_W'($urandom),
                  PHRASE_W'($urandom)));
      at = last_answer.next_node;
    end
    if ($urandom_range(0, 1) == 1) begin
      send(req_of(OP_STEP, at, kw_tok[known_slot()][0], 1'($urandom), BOOST_W'($urandom),
                  THR_W'($urandom), PHRASE_W'($urandom)));
    end
  endtask

  task automatic noise();
    logic [1:0] op;
    case ($urandom_range(0, 2))
      0:       op = OP_INSERT;
      1:       op = OP_STEP;
      default: op = OP_UNUSED;
    endcase
    send(req_of(op, 8'($urandom), TOKEN_W'($urandom), 1'($urandom), BOOST_W'($urandom),
                THR_W'($urandom), PHRASE_W'($urandom)));
  endtask

  task automatic random_group();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) insert_keyword($urandom_range(1, 4), 1'b0);
    else if (r < 85 && kw_total != 0) walk_keyword(known_slot());
    else if (r < 97) noise();
    else send(req_of(OP_CLEAR, 8'($urandom), TOKEN_W'($urandom), 1'($urandom),
                     BOOST_W'($urandom), THR_W'($urandom), PHRASE_W'($urandom)));
  endtask

  task automatic fill_table();
    int unsigned slot;
    while (mirror.node_count < MAX_NODES) insert_keyword($urandom_range(1, 4), 1'b1);
    slot = (kw_total - 1) % KW_SLOTS;
    send(req_of(OP_INSERT, 8'd0, kw_tok[slot][0], 1'b0, BOOST_W'($urandom),
                THR_W'($urandom), PHRASE_W'($urandom)));
    send(req_of(OP_INSERT, 8'd0, TOKEN_W'($urandom), 1'b0, BOOST_W'($urandom),
                THR_W'($urandom), PHRASE_W'($urandom)));
    send(req_of(OP_INSERT, 8'd0, TOKEN_W'($urandom), 1'b1, BOOST_W'($urandom),
                THR_W'($urandom), PHRASE_W'($urandom)));
    send(req_of(OP_INSERT, 8'd0, TOKEN_W'($urandom), 1'b1, BOOST_W'($urandom),
                THR_W'($urandom), PHRASE_W'($urandom)));
    repeat (10) walk_keyword(known_slot());
  endtask

  task automatic directed();
    send(req_of(OP_STEP, 8'd0, '0, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd255, TOKEN_TOP, 1'b1, '1, '1, '1));
    send(req_of(OP_UNUSED, 8'd255, TOKEN_TOP, 1'b1, '1, '1, '1));
    send(req_of(OP_INSERT, 8'd0, TOKEN_TOP, 1'b0, 16'h7FFF, '0, '0));
    send(req_of(OP_INSERT, 8'd255, '0, 1'b1, 16'h8000, 16'hFFFF, 8'hFF));
    send(req_of(OP_INSERT, 8'd0, '0, 1'b1, '0, '0, '0));
    send(req_of(OP_INSERT, 8'd0, TOKEN_TOP, 1'b0, 16'h0001, '0, '0));
    send(req_of(OP_INSERT, 8'd0, '0, 1'b1, 16'h0100, 16'h1234, 8'h7A));
    send(req_of(OP_STEP, 8'd0, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd1, '0, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd2, '0, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd2, 10'd5, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd200, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd3, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_INSERT, 8'd0, TOKEN_TOP, 1'b1, 16'hFF80, 16'h8000, 8'h01));
    send(req_of(OP_STEP, 8'd0, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_CLEAR, 8'd0, '0, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd0, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_INSERT, 8'd0, TOKEN_TOP, 1'b0, 16'h0055, '0, '0));
    send(req_of(OP_STEP, 8'd0, TOKEN_TOP, 1'b0, '0, '0, '0));
    send(req_of(OP_INSERT, 8'd0, 10'd9, 1'b1, 16'hAAAA, 16'h5555, 8'h80));
    send(req_of(OP_STEP, 8'd255, '0, 1'b0, '0, '0, '0));
    send(req_of(OP_STEP, 8'd1, 10'd9, 1'b0, '0, '0, '0));
  endtask

  initial begin
    int unsigned target;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      target = items_sent + 280;
      while (items_sent < target) random_group();
      if (phase == 2) fill_table();
    end
    req_if.valid <= 1'b0;
    while (mirror.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.awaited_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
